// File: hdl/clbs_pkg.sv
// ----------------------------------------------------------------------------
// clbs_pkg
// Shared types and constants of the character LCD bus sequencer: field widths,
// request and phase codes, register indexes and the init command table.
// ----------------------------------------------------------------------------
package clbs_pkg;

  // Field widths
  localparam int unsigned ModeW   = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ColumnW = 7;
  localparam int unsigned LineW   = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned TickW   = 16;
  localparam int unsigned EnW     = 8;

  // Request codes
  localparam logic [ModeW-1:0] ModeTick = 3'd0;
  localparam logic [ModeW-1:0] ModeInit = 3'd1;
  localparam logic [ModeW-1:0] ModeChar = 3'd2;
  localparam logic [ModeW-1:0] ModeGoto = 3'd3;
  localparam logic [ModeW-1:0] ModeRaw  = 3'd4;

  // Sequencer phases
  localparam logic [2:0] PhIdle      = 3'd0;
  localparam logic [2:0] PhPollStart = 3'd1;
  localparam logic [2:0] PhPollHold  = 3'd2;
  localparam logic [2:0] PhPre       = 3'd3;
  localparam logic [2:0] PhWriteHold = 3'd4;
  localparam logic [2:0] PhPost      = 3'd5;

  // Kind of the write in progress
  localparam logic [1:0] KindInit = 2'd0;
  localparam logic [1:0] KindChar = 2'd1;
  localparam logic [1:0] KindCmd  = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPreWait  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCmdHold  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCharPre  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCharPost = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWriteEn  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegReadEn   = 3'd5;

  // Display constants
  localparam logic [ByteW-1:0] CmdSetDdram = 8'h80;
  localparam logic [ByteW-1:0] Line2Offset = 8'h40;
  localparam logic [ByteW-1:0] CmdFuncSet  = 8'h38;
  localparam logic [ByteW-1:0] CmdDispOn   = 8'h0E;
  localparam logic [ByteW-1:0] CmdClear    = 8'h01;
  localparam logic [ByteW-1:0] CmdEntry    = 8'h06;

  // Input transaction
  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [ByteW-1:0]   data_byte;
    logic [ColumnW-1:0] column;
    logic [LineW-1:0]   line;
    logic [ByteW-1:0]   bus_in;
  } req_t;

  // Display pin levels
  typedef struct packed {
    logic             sel;
    logic             e;
    logic             rw;
    logic             rs;
    logic             drive;
    logic [ByteW-1:0] bus;
  } pins_t;

  // Result transaction
  typedef struct packed {
    pins_t pins;
    logic  busy;
    logic  done;
    logic  rejected;
  } res_t;

  // Init command sequence
  function automatic logic [ByteW-1:0] init_cmd(input logic [1:0] idx);
    logic [ByteW-1:0] c;
    case (idx)
      2'd0:    c = CmdFuncSet;
      2'd1:    c = CmdDispOn;
      2'd2:    c = CmdClear;
      2'd3:    c = CmdEntry;
      default: c = CmdFuncSet;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/clbs_if.sv
// ----------------------------------------------------------------------------
// clbs interfaces
// Request, result and configuration channels of the LCD bus sequencer.
// ----------------------------------------------------------------------------
interface clbs_req_if import clbs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ModeW-1:0]   mode;
  logic [ByteW-1:0]   data_byte;
  logic [ColumnW-1:0] column;
  logic [LineW-1:0]   line;
  logic [ByteW-1:0]   bus_in;

  modport source (output valid, mode, data_byte, column, line, bus_in, input ready);
  modport sink   (input valid, mode, data_byte, column, line, bus_in, output ready);
endinterface

interface clbs_res_if import clbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] bus_out;
  logic             bus_drive;
  logic             reg_select;
  logic             read_not_write;
  logic             enable_line;
  logic             select_line;
  logic             sequencer_busy;
  logic             request_done;
  logic             request_rejected;

  modport source (output valid, bus_out, bus_drive, reg_select, read_not_write,
                  enable_line, select_line, sequencer_busy, request_done,
                  request_rejected, input ready);
  modport sink   (input valid, bus_out, bus_drive, reg_select, read_not_write,
                  enable_line, select_line, sequencer_busy, request_done,
                  request_rejected, output ready);
endinterface

interface clbs_cfg_if import clbs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/char_lcd_bus_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer
// Drives the 8-bit parallel bus of a character LCD from ticks and requests.
// ----------------------------------------------------------------------------
//   channel  | direction | contents
//   req_i    | in        | mode, data_byte, column, line, bus_in
//   res_o    | out       | pin levels, sequencer_busy, request_done, rejected
//   cfg_i    | in        | register index, write data (always ready)
//
// Every transaction passes through the input register, then through the
// phase update into the result register. One transaction is accepted per
// cycle; the input register advances whenever the result register is empty
// or being taken. Reset returns the sequencer to idle with the bus driven low
// and the timing registers at their defaults. A stalled result holds the
// result register; the input register still fills once, then holds and drops
// req_i.ready until the result is taken.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer import clbs_pkg::*; #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  clbs_req_if.sink    req_i,
  clbs_res_if.source  res_o,
  clbs_cfg_if.sink    cfg_i
);

  localparam logic [31:0] DlyMax = 32'((64'd1 << DELAY_WIDTH) - 64'd1);

  // Saturate a timing value into the delay counter
  function automatic logic [DELAY_WIDTH-1:0] load_dly(input logic [TickW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > DlyMax) begin
      w = DlyMax;
    end
    return w[DELAY_WIDTH-1:0];
  endfunction

  // Configuration registers
  logic [TickW-1:0] pre_wait_q, cmd_hold_q, char_pre_q, char_post_q;
  logic [EnW-1:0]   write_en_q, read_en_q;

  // Pipeline registers
  logic s1_valid_q, out_valid_q;
  req_t s1_q;
  res_t out_q;
  logic s1_adv, s1_fire;

  // Sequencer state
  logic [2:0]             phase_q, phase_d;
  logic [DELAY_WIDTH-1:0] cnt_q, cnt_d;
  logic [1:0]             idx_q, idx_d;
  logic [ByteW-1:0]       pend_q, pend_d;
  logic [1:0]             kind_q, kind_d;
  pins_t                  pins_q, pins_d;
  logic                   done_d, rej_d;
  logic [ByteW-1:0]       addr;

  assign cfg_i.ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_wait_q  <= TickW'(80);
      cmd_hold_q  <= TickW'(156);
      char_pre_q  <= TickW'(32);
      char_post_q <= TickW'(172);
      write_en_q  <= EnW'(1);
      read_en_q   <= EnW'(2);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegPreWait:  pre_wait_q  <= cfg_i.data;
        RegCmdHold:  cmd_hold_q  <= cfg_i.data;
        RegCharPre:  char_pre_q  <= cfg_i.data;
        RegCharPost: char_post_q <= cfg_i.data;
        RegWriteEn:  write_en_q  <= cfg_i.data[EnW-1:0];
        RegReadEn:   read_en_q   <= cfg_i.data[EnW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the input register when the result register can take a result
  assign s1_adv      = !out_valid_q || res_o.ready;
  assign s1_fire     = s1_valid_q && s1_adv;
  assign req_i.ready = !s1_valid_q || s1_adv;

  // Capture the input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_q <= '{mode: req_i.mode, data_byte: req_i.data_byte, column: req_i.column,
                line: req_i.line, bus_in: req_i.bus_in};
    end
  end

  // Goto address: zero-based column, line 2 offset, set-DDRAM bit
  always_comb begin
    addr = ByteW'({1'b0, s1_q.column} - 8'd1);
    if (s1_q.line == 2'd2) begin
      addr = addr + Line2Offset;
    end
    addr = addr | CmdSetDdram;
  end

  // Phase update for one transaction
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    pend_d  = pend_q;
    kind_d  = kind_q;
    pins_d  = pins_q;
    done_d  = 1'b0;
    rej_d   = 1'b0;
    if (s1_q.mode == ModeTick) begin
      case (phase_q)
        PhIdle: ;
        PhPollStart: begin
          pins_d.drive = 1'b0;
          pins_d.rw    = 1'b1;
          pins_d.rs    = 1'b0;
          pins_d.e     = 1'b1;
          pins_d.sel   = 1'b1;
          cnt_d        = load_dly(TickW'(read_en_q));
          phase_d      = PhPollHold;
        end
        PhPollHold: begin
          if (cnt_q > DELAY_WIDTH'(1)) begin
            cnt_d = cnt_q - DELAY_WIDTH'(1);
          end else begin
            pins_d.e     = 1'b0;
            pins_d.sel   = 1'b1;
            pins_d.drive = 1'b1;
            if (s1_q.bus_in[7]) begin
              phase_d = PhPollStart;
            end else begin
              cnt_d   = load_dly((kind_q == KindChar) ? char_pre_q : pre_wait_q);
              phase_d = PhPre;
            end
          end
        end
        PhPre: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - DELAY_WIDTH'(1);
          end else begin
            pins_d.rs    = (kind_q == KindChar);
            pins_d.rw    = 1'b0;
            pins_d.e     = 1'b1;
            pins_d.sel   = 1'b1;
            pins_d.bus   = pend_q;
            pins_d.drive = 1'b1;
            cnt_d        = load_dly(TickW'(write_en_q));
            phase_d      = PhWriteHold;
          end
        end
        PhWriteHold: begin
          if (cnt_q > DELAY_WIDTH'(1)) begin
            cnt_d = cnt_q - DELAY_WIDTH'(1);
          end else begin
            pins_d.e   = 1'b0;
            pins_d.sel = 1'b1;
            if (kind_q == KindInit) begin
              cnt_d = load_dly(cmd_hold_q);
            end else if (kind_q == KindChar) begin
              cnt_d = load_dly(char_post_q);
            end else begin
              cnt_d = '0;
            end
            phase_d = PhPost;
          end
        end
        PhPost: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - DELAY_WIDTH'(1);
          end else if (kind_q == KindInit && idx_q != 2'd3) begin
            idx_d   = idx_q + 2'd1;
            pend_d  = init_cmd(idx_q + 2'd1);
            phase_d = PhPollStart;
          end else begin
            phase_d = PhIdle;
            done_d  = 1'b1;
          end
        end
        default: phase_d = PhIdle;
      endcase
    end else if (phase_q == PhIdle) begin
      case (s1_q.mode)
        ModeInit: begin
          kind_d  = KindInit;
          idx_d   = 2'd0;
          pend_d  = init_cmd(2'd0);
          phase_d = PhPollStart;
        end
        ModeChar: begin
          kind_d  = KindChar;
          pend_d  = s1_q.data_byte;
          phase_d = PhPollStart;
        end
        ModeGoto, ModeRaw: begin
          if (s1_q.mode == ModeGoto && s1_q.line != 2'd1 && s1_q.line != 2'd2) begin
            done_d = 1'b1;
            rej_d  = 1'b1;
          end else begin
            kind_d  = KindCmd;
            pend_d  = (s1_q.mode == ModeGoto) ? addr : s1_q.data_byte;
            cnt_d   = '0;
            phase_d = PhPre;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold sequencer state, update on each processed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= '0;
      idx_q   <= 2'd0;
      pend_q  <= '0;
      kind_q  <= KindInit;
      pins_q  <= '{sel: 1'b0, e: 1'b0, rw: 1'b0, rs: 1'b0, drive: 1'b1, bus: '0};
    end else if (s1_fire) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      kind_q  <= kind_d;
      pins_q  <= pins_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= '{pins: pins_d, busy: (phase_d != PhIdle), done: done_d, rejected: rej_d};
    end
  end

  // Drive the result channel
  assign res_o.valid            = out_valid_q;
  assign res_o.bus_out          = out_q.pins.bus;
  assign res_o.bus_drive        = out_q.pins.drive;
  assign res_o.reg_select       = out_q.pins.rs;
  assign res_o.read_not_write   = out_q.pins.rw;
  assign res_o.enable_line      = out_q.pins.e;
  assign res_o.select_line      = out_q.pins.sel;
  assign res_o.sequencer_busy   = out_q.busy;
  assign res_o.request_done     = out_q.done;
  assign res_o.request_rejected = out_q.rejected;

endmodule

// File: hdl/clbs_checker.sv
// ----------------------------------------------------------------------------
// clbs_checker
// Port-level checks of the LCD bus sequencer results, bound to the top level.
// ----------------------------------------------------------------------------
module clbs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [7:0] bus_out_i,
  input logic       bus_drive_i,
  input logic       reg_select_i,
  input logic       read_not_write_i,
  input logic       enable_line_i,
  input logic       select_line_i,
  input logic       busy_i,
  input logic       done_i,
  input logic       rejected_i
);

  // A rejected goto finishes at once and leaves the sequencer idle
  a_reject_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && rejected_i |-> done_i && !busy_i)
    else $error("rejected request without done or with busy");

  // A finished request leaves nothing in progress
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && done_i |-> !busy_i)
    else $error("done while still busy");

  // A released bus only happens during a status read
  a_release_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !bus_drive_i |-> read_not_write_i && !reg_select_i && busy_i)
    else $error("bus released outside a status read");

  // Enable is only raised through a control update, which sets select
  a_enable_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && enable_line_i |-> select_line_i)
    else $error("enable high without select");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(bus_out_i)
      && $stable(busy_i) && $stable(done_i))
    else $error("stalled result changed");

endmodule

bind char_lcd_bus_sequencer clbs_checker u_clbs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .bus_out_i        (res_o.bus_out),
  .bus_drive_i      (res_o.bus_drive),
  .reg_select_i     (res_o.reg_select),
  .read_not_write_i (res_o.read_not_write),
  .enable_line_i    (res_o.enable_line),
  .select_line_i    (res_o.select_line),
  .busy_i           (res_o.sequencer_busy),
  .done_i           (res_o.request_done),
  .rejected_i       (res_o.request_rejected)
);
